### src/sbus_frame_decoder_with_stale_watch_top_assert.svh
// Assertion macros for the SBUS frame decoder top level.
`ifndef SBUS_FRAME_DECODER_WITH_STALE_WATCH_TOP_ASSERT_SVH
`define SBUS_FRAME_DECODER_WITH_STALE_WATCH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Implication checked at every clock edge outside reset.
`define SBUSFD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbusfd: check failed");

// Non-overlapping implication: the consequence is checked at the next clock edge.
`define SBUSFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbusfd: check failed");

`else

`define SBUSFD_ASSERT_IMPL(lbl, ante, cons)
`define SBUSFD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### src/sbusfd_pkg.sv
// Shared constants and types of the SBUS frame decoder.
package sbusfd_pkg;

  // Frame layout.
  localparam int FRAME_LEN   = 25;
  localparam int FLAGS_POS   = 23;
  localparam int DATA_BYTES  = 22;
  localparam int POS_W       = 5;
  localparam int CHAN_COUNT  = 16;
  localparam int CHAN_W      = 11;
  localparam int CHAN_IDX_W  = 4;
  localparam int CHAN_BITS   = CHAN_COUNT * CHAN_W;

  localparam logic [7:0] HEADER_BYTE = 8'h0F;
  localparam logic [7:0] END_BYTE    = 8'h00;

  // Configuration registers.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_CAP        = 1'b1;
  localparam logic [7:0] OFFLINE_THRESHOLD_RST = 8'd100;
  localparam logic [7:0] REPEAT_CAP_RST        = 8'd200;

  // Verdict on one completed frame, handed from the tracker to the emitter.
  typedef struct packed {
    logic                 done;
    logic                 ok;
    logic [7:0]           flags;
    logic                 offline;
    logic [CHAN_BITS-1:0] chans;
  } frame_res_t;

endpackage

### src/sbusfd_frame_track.sv
// Byte position tracking, frame capture, repeat counting and frame checks.
module sbusfd_frame_track (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   acc,
  input  logic [7:0]             rx_byte,
  input  logic                   frame_gap,
  input  logic [7:0]             offline_threshold,
  input  logic [7:0]             repeat_cap,
  output logic                   completes,
  output sbusfd_pkg::frame_res_t res
);

  logic [sbusfd_pkg::POS_W-1:0] pos_r;
  logic [sbusfd_pkg::POS_W-1:0] pos_eff;
  logic [7:0]                   fs_r   [sbusfd_pkg::FRAME_LEN-1];
  logic [7:0]                   prev_r [sbusfd_pkg::FRAME_LEN];
  logic                         diff_r;
  logic                         diff_nxt;
  logic [7:0]                   rc_r;
  logic [7:0]                   rc_nxt;
  logic                         active;
  logic [7:0]                   prev_byte;

  // A gap restarts the frame; positions past the end byte are surplus.
  assign pos_eff   = frame_gap ? '0 : pos_r;
  assign active    = (pos_eff < sbusfd_pkg::POS_W'(sbusfd_pkg::FRAME_LEN));
  assign completes = (pos_eff == sbusfd_pkg::POS_W'(sbusfd_pkg::FRAME_LEN - 1));
  assign prev_byte = active ? prev_r[pos_eff] : rx_byte;

  // Difference against the previous frame, cleared at the first byte.
  assign diff_nxt = ((pos_eff != '0) && diff_r) || (prev_byte != rx_byte);

  // Repeat counter rises on an identical frame below the cap, else halves.
  always_comb begin
    if (!diff_nxt && (rc_r < repeat_cap)) begin
      rc_nxt = rc_r + 8'd1;
    end else begin
      rc_nxt = {1'b0, rc_r[7:1]};
    end
  end

  // Frame verdict and little-endian channel bits from bytes 1 to 22.
  always_comb begin
    res.done    = acc && completes;
    res.ok      = (fs_r[0] == sbusfd_pkg::HEADER_BYTE) &&
                  (rx_byte == sbusfd_pkg::END_BYTE) &&
                  (fs_r[sbusfd_pkg::FLAGS_POS] == 8'h00);
    res.flags   = fs_r[sbusfd_pkg::FLAGS_POS];
    res.offline = (rc_nxt >= offline_threshold);
    for (int i = 0; i < sbusfd_pkg::DATA_BYTES; i++) begin
      res.chans[i*8 +: 8] = fs_r[i+1];
    end
  end

  // Frame capture as a shift line: byte 0 ends at the bottom after 24 bytes.
  always_ff @(posedge clk) begin
    if (acc && active) begin
      for (int i = 0; i < sbusfd_pkg::FRAME_LEN - 2; i++) begin
        fs_r[i] <= fs_r[i+1];
      end
      fs_r[sbusfd_pkg::FRAME_LEN-2] <= rx_byte;
    end
  end

  // Position, previous frame, difference flag and repeat counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      diff_r <= 1'b0;
      rc_r   <= '0;
      for (int i = 0; i < sbusfd_pkg::FRAME_LEN; i++) begin
        prev_r[i] <= '0;
      end
    end else if (acc && active) begin
      pos_r           <= pos_eff + sbusfd_pkg::POS_W'(1);
      diff_r          <= diff_nxt;
      prev_r[pos_eff] <= rx_byte;
      if (completes) begin
        rc_r <= rc_nxt;
      end
    end
  end

endmodule

### src/sbusfd_emit.sv
// Result register that hands out the channels of one frame, one per cycle while out_ready is high.
module sbusfd_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sbusfd_pkg::frame_res_t              res,
  input  logic                                out_ready,
  output logic                                can_load,
  output logic                                out_valid,
  output logic [sbusfd_pkg::CHAN_IDX_W-1:0]   out_channel_index,
  output logic [sbusfd_pkg::CHAN_W-1:0]       out_channel_value,
  output logic                                out_frame_ok,
  output logic [7:0]                          out_flags_byte,
  output logic                                out_link_offline,
  output logic                                out_last
);

  logic                                vld_r;
  logic [sbusfd_pkg::CHAN_IDX_W-1:0]   idx_r;
  logic [sbusfd_pkg::CHAN_BITS-1:0]    data_r;
  logic                                ok_r;
  logic [7:0]                          flags_r;
  logic                                off_r;
  logic                                last;

  // A rejected frame gives a single result; a good one ends at channel 15.
  assign last = !ok_r || (idx_r == sbusfd_pkg::CHAN_IDX_W'(sbusfd_pkg::CHAN_COUNT - 1));
  assign can_load = !vld_r || (out_ready && last);

  assign out_valid         = vld_r;
  assign out_channel_index = idx_r;
  assign out_channel_value = data_r[sbusfd_pkg::CHAN_W-1:0];
  assign out_frame_ok      = ok_r;
  assign out_flags_byte    = flags_r;
  assign out_link_offline  = off_r;
  assign out_last          = last;

  // Valid flag: set by a new frame, cleared once its last item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res.done) begin
      vld_r <= 1'b1;
    end else if (vld_r && out_ready && last) begin
      vld_r <= 1'b0;
    end
  end

  // Payload: load the frame, then step one channel per item taken.
  always_ff @(posedge clk) begin
    if (res.done) begin
      idx_r   <= '0;
      data_r  <= res.ok ? res.chans : '0;
      ok_r    <= res.ok;
      flags_r <= res.flags;
      off_r   <= res.offline;
    end else if (vld_r && out_ready && !last) begin
      idx_r  <= idx_r + sbusfd_pkg::CHAN_IDX_W'(1);
      data_r <= data_r >> sbusfd_pkg::CHAN_W;
    end
  end

endmodule

### src/sbus_frame_decoder_with_stale_watch_top.sv
// Top level of the SBUS frame decoder with stale-link watch.
// The decoder takes one received byte per cycle. On the 25th byte of a frame
// it checks the header, end and flags bytes and updates the repeat counter; a
// good frame then leaves the result register as sixteen channel items, one
// per cycle, and a rejected frame as a single item. Bytes keep being accepted
// while channels are handed out; only the 25th byte of the next frame waits
// until the last item of the previous frame has been taken, so a good frame
// needs at least 16 cycles at the result port. Configuration writes take
// effect at the next clock edge.
module sbus_frame_decoder_with_stale_watch_top (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [7:0]                                   in_rx_byte,
  input  logic                                         in_frame_gap,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic [sbusfd_pkg::CHAN_IDX_W-1:0]            out_channel_index,
  output logic [sbusfd_pkg::CHAN_W-1:0]                out_channel_value,
  output logic                                         out_frame_ok,
  output logic [7:0]                                   out_flags_byte,
  output logic                                         out_link_offline,
  output logic                                         out_last,
  input  logic                                         cfg_wr_en,
  input  logic [sbusfd_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [7:0]                                   cfg_wdata
);

`include "sbus_frame_decoder_with_stale_watch_top_assert.svh"

  logic [7:0]             offline_threshold_r;
  logic [7:0]             repeat_cap_r;
  logic                   completes;
  logic                   can_load;
  logic                   acc;
  sbusfd_pkg::frame_res_t res;

  // The completing byte waits while an earlier frame still holds the result register.
  assign in_ready = !completes || can_load;
  assign acc      = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offline_threshold_r <= sbusfd_pkg::OFFLINE_THRESHOLD_RST;
      repeat_cap_r        <= sbusfd_pkg::REPEAT_CAP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sbusfd_pkg::CFG_OFFLINE_THRESHOLD: offline_threshold_r <= cfg_wdata;
        sbusfd_pkg::CFG_REPEAT_CAP:        repeat_cap_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sbusfd_frame_track u_track (
    .clk               (clk),
    .rst_n             (rst_n),
    .acc               (acc),
    .rx_byte           (in_rx_byte),
    .frame_gap         (in_frame_gap),
    .offline_threshold (offline_threshold_r),
    .repeat_cap        (repeat_cap_r),
    .completes         (completes),
    .res               (res)
  );

  sbusfd_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .res               (res),
    .out_ready         (out_ready),
    .can_load          (can_load),
    .out_valid         (out_valid),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_frame_ok      (out_frame_ok),
    .out_flags_byte    (out_flags_byte),
    .out_link_offline  (out_link_offline),
    .out_last          (out_last)
  );

  // A completed frame never overwrites an item that has not been taken.
  `SBUSFD_ASSERT_IMPL(a_no_overwrite, acc && completes, !out_valid || (out_ready && out_last))
  // A rejected frame gives one item with zero channel number and value.
  `SBUSFD_ASSERT_IMPL(a_reject_single, out_valid && !out_frame_ok, out_last && (out_channel_index == '0) && (out_channel_value == '0))
  // A good frame always carries a clear flags byte.
  `SBUSFD_ASSERT_IMPL(a_ok_flags, out_valid && out_frame_ok, out_flags_byte == 8'h00)
  // Channels of a good frame follow one another without a hole.
  `SBUSFD_ASSERT_NEXT(a_chan_step, out_valid && out_ready && !out_last, out_valid && (out_channel_index == $past(out_channel_index) + 4'd1))

endmodule

### tb/tb.sv
// Self-checking testbench for the SBUS frame decoder with stale-link watch.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 8;

  // One channel item as it leaves the decoder.
  typedef struct packed {
    logic [sbusfd_pkg::CHAN_IDX_W-1:0] idx;
    logic [sbusfd_pkg::CHAN_W-1:0]     val;
    logic                              ok;
    logic [7:0]                        flags;
    logic                              offline;
    logic                              last;
  } chan_item_t;

  // Tracks frame bytes, the repeat counter and the channel items still owed.
  class frame_judge;
    logic [7:0]                   cur_bytes [sbusfd_pkg::FRAME_LEN];
    logic [7:0]                   prev_bytes [sbusfd_pkg::FRAME_LEN];
    logic [sbusfd_pkg::POS_W-1:0] fill;
    logic                         changed;
    logic [7:0]                   repeats;
    logic [7:0]                   threshold;
    logic [7:0]                   cap;
    chan_item_t                   due_channels [$];
    int unsigned                  bad_count;

    function new();
      foreach (cur_bytes[i]) begin
        cur_bytes[i]  = 8'h00;
        prev_bytes[i] = 8'h00;
      end
      fill      = '0;
      changed   = 1'b0;
      repeats   = 8'h00;
      threshold = sbusfd_pkg::OFFLINE_THRESHOLD_RST;
      cap       = sbusfd_pkg::REPEAT_CAP_RST;
      bad_count = 0;
    endfunction

    function void set_reg(logic [sbusfd_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        sbusfd_pkg::CFG_OFFLINE_THRESHOLD: threshold = val;
        sbusfd_pkg::CFG_REPEAT_CAP:        cap = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return due_channels.size();
    endfunction

    // Account for one accepted byte and queue whatever the frame yields.
    function void take_byte(logic [7:0] b, logic gap);
      logic [sbusfd_pkg::CHAN_BITS-1:0] chan_bits;
      chan_item_t                       item;
      logic                             offline;
      logic                             good;
      logic [7:0]                       flags;
      if (gap)
        fill = '0;
      // Bytes past the end of a frame are dropped until the next gap.
      if (fill >= sbusfd_pkg::FRAME_LEN)
        return;
      cur_bytes[fill] = b;
      if (fill == 0)
        changed = 1'b0;
      if (prev_bytes[fill] != b)
        changed = 1'b1;
      prev_bytes[fill] = b;
      fill = fill + 1'b1;
      if (fill != sbusfd_pkg::FRAME_LEN)
        return;

      // Repeat counter climbs on identical frames below the cap, else halves.
      if (!changed && repeats < cap)
        repeats = repeats + 8'd1;
      else
        repeats = repeats >> 1;
      offline = (repeats >= threshold);
      flags   = cur_bytes[sbusfd_pkg::FLAGS_POS];
      good    = (cur_bytes[0] == sbusfd_pkg::HEADER_BYTE) &&
                (cur_bytes[sbusfd_pkg::FRAME_LEN-1] == sbusfd_pkg::END_BYTE) &&
                (flags == 8'h00);

      if (!good) begin
        item = '{idx: '0, val: '0, ok: 1'b0, flags: flags, offline: offline, last: 1'b1};
        due_channels.push_back(item);
        return;
      end
      // Channel data is a little-endian bit stream over the payload bytes.
      for (int i = 0; i < sbusfd_pkg::DATA_BYTES; i++)
        chan_bits[i*8 +: 8] = cur_bytes[i+1];
      for (int k = 0; k < sbusfd_pkg::CHAN_COUNT; k++) begin
        item.idx     = sbusfd_pkg::CHAN_IDX_W'(k);
        item.val     = chan_bits[k*sbusfd_pkg::CHAN_W +: sbusfd_pkg::CHAN_W];
        item.ok      = 1'b1;
        item.flags   = flags;
        item.offline = offline;
        item.last    = (k == sbusfd_pkg::CHAN_COUNT - 1);
        due_channels.push_back(item);
      end
    endfunction

    // Compare one accepted channel item with the oldest one owed.
    function void match_channel(chan_item_t got);
      chan_item_t want;
      if (due_channels.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: unexpected item idx %0d val %0d ok %0d flags %02h off %0d last %0d",
                   $realtime, got.idx, got.val, got.ok, got.flags, got.offline, got.last);
        return;
      end
      want = due_channels.pop_front();
      if (got.idx !== want.idx || got.val !== want.val || got.ok !== want.ok ||
          got.flags !== want.flags || got.offline !== want.offline ||
          got.last !== want.last) begin
        bad_count++;
        if (bad_count <= 10) begin
          $display("%0t: item mismatch", $realtime);
          $display("  expected idx %0d val %0d ok %0d flags %02h off %0d last %0d",
                   want.idx, want.val, want.ok, want.flags, want.offline, want.last);
          $display("  actual   idx %0d val %0d ok %0d flags %02h off %0d last %0d",
                   got.idx, got.val, got.ok, got.flags, got.offline, got.last);
        end
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n             = 1'b0;
  logic                              in_valid          = 1'b0;
  logic                              in_ready;
  logic [7:0]                        in_rx_byte        = 8'h00;
  logic                              in_frame_gap      = 1'b0;
  logic                              out_valid;
  logic                              out_ready         = 1'b0;
  logic [sbusfd_pkg::CHAN_IDX_W-1:0] out_channel_index;
  logic [sbusfd_pkg::CHAN_W-1:0]     out_channel_value;
  logic                              out_frame_ok;
  logic [7:0]                        out_flags_byte;
  logic                              out_link_offline;
  logic                              out_last;
  logic                              cfg_wr_en         = 1'b0;
  logic [sbusfd_pkg::CFG_IDX_W-1:0]  cfg_index         = '0;
  logic [7:0]                        cfg_wdata         = 8'h00;

  frame_judge  jud;
  logic [7:0]  frm [sbusfd_pkg::FRAME_LEN];
  int unsigned sent_bytes = 0;
  bit          calm       = 1'b0;
  int          hold_seq   = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;

  sbus_frame_decoder_with_stale_watch_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .in_frame_gap      (in_frame_gap),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_channel_index (out_channel_index),
    .out_channel_value (out_channel_value),
    .out_frame_ok      (out_frame_ok),
    .out_flags_byte    (out_flags_byte),
    .out_link_offline  (out_link_offline),
    .out_last          (out_last),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // 50 MHz clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result side: check each taken item, then decide readiness for the next edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      jud.match_channel(chan_item_t'{idx: out_channel_index, val: out_channel_value,
                                     ok: out_frame_ok, flags: out_flags_byte,
                                     offline: out_link_offline, last: out_last});
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Offer one byte, idling now and then first, and wait until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic g);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_rx_byte   <= b;
    in_frame_gap <= g;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    jud.take_byte(b, g);
    sent_bytes++;
  endtask

  // Send the first n bytes of the frame buffer.
  task automatic send_frame(input int n, input logic first_gap);
    for (int i = 0; i < n; i++)
      send_byte(frm[i], (i == 0) ? first_gap : 1'b0);
  endtask

  // Fill the frame buffer with a well-formed frame; payload all low, all high or random.
  task automatic build_good();
    int mode;
    mode = $urandom_range(0, 9);
    frm[0] = sbusfd_pkg::HEADER_BYTE;
    for (int i = 1; i <= sbusfd_pkg::DATA_BYTES; i++)
      frm[i] = (mode == 0) ? 8'h00 : (mode == 1) ? 8'hFF : 8'($urandom_range(0, 255));
    frm[sbusfd_pkg::FLAGS_POS]   = 8'h00;
    frm[sbusfd_pkg::FRAME_LEN-1] = sbusfd_pkg::END_BYTE;
  endtask

  // Break exactly one of the header, flags or end checks.
  task automatic spoil_frame();
    case ($urandom_range(0, 2))
      0:       frm[0] = sbusfd_pkg::HEADER_BYTE ^ 8'($urandom_range(1, 255));
      1:       frm[sbusfd_pkg::FLAGS_POS] = 8'($urandom_range(1, 255));
      default: frm[sbusfd_pkg::FRAME_LEN-1] = sbusfd_pkg::END_BYTE ^ 8'($urandom_range(1, 255));
    endcase
  endtask

  // Mixture of repeated, fresh, rejected and cut-short frames, with stray noise.
  task automatic run_random(input int unsigned budget);
    int unsigned base;
    int          kind;
    base = sent_bytes;
    while (sent_bytes - base < budget) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        send_frame(sbusfd_pkg::FRAME_LEN, 1'b1);
      end else if (kind < 65) begin
        build_good();
        send_frame(sbusfd_pkg::FRAME_LEN, 1'b1);
      end else if (kind < 80) begin
        build_good();
        spoil_frame();
        send_frame(sbusfd_pkg::FRAME_LEN, 1'b1);
      end else if (kind < 88) begin
        build_good();
        send_frame($urandom_range(1, sbusfd_pkg::FRAME_LEN - 1), 1'b1);
      end else begin
        repeat ($urandom_range(1, 8))
          send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
      end
      // Trailing bytes after a complete frame must be ignored.
      if (kind < 80 && $urandom_range(0, 99) < 20)
        repeat ($urandom_range(1, 3))
          send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Stop offering and wait until every owed item has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (jud.pending() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both registers back to back.
  task automatic write_regs(input logic [7:0] thr, input logic [7:0] cap);
    cfg_wr_en <= 1'b1;
    cfg_index <= sbusfd_pkg::CFG_OFFLINE_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    jud.set_reg(sbusfd_pkg::CFG_OFFLINE_THRESHOLD, thr);
    cfg_index <= sbusfd_pkg::CFG_REPEAT_CAP;
    cfg_wdata <= cap;
    @(posedge clk);
    jud.set_reg(sbusfd_pkg::CFG_REPEAT_CAP, cap);
    cfg_wr_en <= 1'b0;
  endtask

  // Main sequence.
  initial begin
    jud = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first frame straight after reset without a gap, payload all ones,
    // then a trailing byte that must be dropped.
    build_good();
    for (int i = 1; i <= sbusfd_pkg::DATA_BYTES; i++)
      frm[i] = 8'hFF;
    send_frame(sbusfd_pkg::FRAME_LEN, 1'b0);
    send_byte(8'h00, 1'b0);
    drain();

    // Low threshold and cap: offline reporting and halving at the cap.
    write_regs(8'd1, 8'd2);
    run_random(20);
    drain();

    // Zero cap and threshold: the count never rises and the link is always offline.
    write_regs(8'd0, 8'd0);
    run_random(20);
    drain();

    // Top values, with no idling on either side.
    calm = 1'b1;
    write_regs(8'd255, 8'd255);
    run_random(15);
    drain();
    calm = 1'b0;

    // Result side holds off while repeated good frames pile up behind it.
    write_regs(8'd2, 8'd3);
    hold_seq <= hold_seq + 1;
    build_good();
    repeat (2)
      send_frame(sbusfd_pkg::FRAME_LEN, 1'b1);
    run_random(15);
    drain();

    if (jud.bad_count == 0 && jud.pending() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/sbusfd_pkg.sv
src/sbusfd_frame_track.sv
src/sbusfd_emit.sv
src/sbus_frame_decoder_with_stale_watch_top.sv
tb/tb.sv
